// ===== hdl/imu_fall_detector_macros.svh =====
// Assertion macros for the fall detector.
`ifndef IMU_FALL_DETECTOR_MACROS_SVH
`define IMU_FALL_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define FD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FD_ASSERT_NEVER(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);
`else
`define FD_ASSERT(label, prop, msg)
`define FD_ASSERT_NEVER(label, prop, msg)
`endif
`endif

// ===== hdl/imufd_pkg.sv =====
package imufd_pkg;
	localparam int WINDOW_LEN_DEF = 20;
	localparam int AXIS_W = 16;
	localparam int THR_W = 16;
	localparam int LIM_W = 7;
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;
	localparam logic [THR_W-1:0] ACCEL_THR_RST = 16'd4000;
	localparam logic [THR_W-1:0] GYRO_THR_RST = 16'd1500;
	localparam logic [LIM_W-1:0] ACCEL_LIM_RST = 7'd5;
	localparam logic [LIM_W-1:0] GYRO_LIM_RST = 7'd3;
	localparam logic [THR_W-1:0] QUIET_RST = 16'd400;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	typedef enum logic [IDX_W-1:0] {
		REG_ACCEL_THR = 3'd0,
		REG_GYRO_THR = 3'd1,
		REG_ACCEL_LIM = 3'd2,
		REG_GYRO_LIM = 3'd3,
		REG_QUIET = 3'd4
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ = 6'b000010,
		ST_ROOT = 6'b000100,
		ST_WR = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_DEC = 6'b100000
	} state_t;
endpackage

// ===== hdl/imu_fall_detector.sv =====
// The block takes one sample at a time: a new input beat is accepted only in the idle
// state, after the previous result has been issued. The window scan reads the
// window memory one entry per cycle, and the two square roots are found bit by bit together.
// A stalled result beat holds the decision step, and with it the next input beat.
// Reset is asynchronous and active low; it clears the control state, the window valid bits
// and the configuration registers to their default values.
`include "imu_fall_detector_macros.svh"
module imu_fall_detector #(
	parameter int WINDOW_LEN = imufd_pkg::WINDOW_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [imufd_pkg::IDX_W-1:0] cfg_index,
	input  logic [imufd_pkg::CFG_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic [95:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// fall_alarm, fall_candidate, zero fill
	output logic [7:0] m_tdata
);
	localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_LEN - 1);
	localparam logic [CW-1:0] SCAN_END = CW'(WINDOW_LEN);

	imufd_pkg::state_t state_q;
	logic [15:0] accel_thr_q, gyro_thr_q, quiet_q;
	logic [6:0] accel_lim_q, gyro_lim_q;

	logic [95:0] axes_q;
	logic [2:0] sq_cnt_q;
	logic [31:0] prod_q, sum_a_q, sum_g_q;
	logic [31:0] rem_a_q, rem_g_q, res_a_q, res_g_q, bit_q;
	logic [3:0] it_q;
	logic [15:0] prev_a_q, prev_g_q;
	logic [AW-1:0] wp_q;
	logic [WINDOW_LEN-1:0] valid_q;
	logic [31:0] mem [WINDOW_LEN];
	logic [31:0] rd_data_s1;
	logic rd_en_s1, rd_vld_s1;
	logic [CW-1:0] scan_q, acnt_q, gcnt_q;
	logic held_q;
	logic [15:0] ticks_q;

	logic [15:0] axis_sel;
	logic [16:0] axis_abs;
	logic [33:0] axis_sq;
	logic [31:0] try_a, try_g;
	logic [15:0] mag_a, mag_g, diff_a, diff_g;
	logic cand, held_n, alarm, out_free;
	logic [15:0] ticks_n;

	assign s_tready = (state_q == imufd_pkg::ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		axis_sel = (sq_cnt_q < 3'd6) ? axes_q[sq_cnt_q*16 +: 16] : 16'd0;
		axis_abs = axis_sel[15] ? (17'd0 - {1'b1, axis_sel}) : {1'b0, axis_sel};
		axis_sq = {17'd0, axis_abs} * {17'd0, axis_abs};
		try_a = res_a_q + bit_q;
		try_g = res_g_q + bit_q;
		mag_a = res_a_q[15:0];
		mag_g = res_g_q[15:0];
		diff_a = (mag_a > prev_a_q) ? mag_a - prev_a_q : prev_a_q - mag_a;
		diff_g = (mag_g > prev_g_q) ? mag_g - prev_g_q : prev_g_q - mag_g;
		cand = (7'(acnt_q) > accel_lim_q) && (7'(gcnt_q) > gyro_lim_q);
		held_n = cand || held_q;
		if (cand) begin
			ticks_n = 16'd0;
		end else if (ticks_q != imufd_pkg::TICK_MAX) begin
			ticks_n = ticks_q + 16'd1;
		end else begin
			ticks_n = ticks_q;
		end
		alarm = held_n && (ticks_n > quiet_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q <= imufd_pkg::ACCEL_THR_RST;
			gyro_thr_q <= imufd_pkg::GYRO_THR_RST;
			accel_lim_q <= imufd_pkg::ACCEL_LIM_RST;
			gyro_lim_q <= imufd_pkg::GYRO_LIM_RST;
			quiet_q <= imufd_pkg::QUIET_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				imufd_pkg::REG_ACCEL_THR: accel_thr_q <= cfg_wdata;
				imufd_pkg::REG_GYRO_THR: gyro_thr_q <= cfg_wdata;
				imufd_pkg::REG_ACCEL_LIM: accel_lim_q <= cfg_wdata[6:0];
				imufd_pkg::REG_GYRO_LIM: gyro_lim_q <= cfg_wdata[6:0];
				imufd_pkg::REG_QUIET: quiet_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == imufd_pkg::ST_WR) begin
			mem[wp_q] <= {diff_g, diff_a};
		end
		rd_data_s1 <= mem[scan_q[AW-1:0]];
		rd_vld_s1 <= valid_q[scan_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imufd_pkg::ST_IDLE;
			axes_q <= '0;
			sq_cnt_q <= '0;
			prod_q <= '0;
			sum_a_q <= '0;
			sum_g_q <= '0;
			rem_a_q <= '0;
			rem_g_q <= '0;
			res_a_q <= '0;
			res_g_q <= '0;
			bit_q <= '0;
			it_q <= '0;
			prev_a_q <= '0;
			prev_g_q <= '0;
			wp_q <= '0;
			valid_q <= '0;
			rd_en_s1 <= 1'b0;
			scan_q <= '0;
			acnt_q <= '0;
			gcnt_q <= '0;
			held_q <= 1'b0;
			ticks_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != imufd_pkg::ST_DEC)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				imufd_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						axes_q <= s_tdata;
						sq_cnt_q <= '0;
						sum_a_q <= '0;
						sum_g_q <= '0;
						state_q <= imufd_pkg::ST_SQ;
					end
				end
				imufd_pkg::ST_SQ: begin
					prod_q <= axis_sq[31:0];
					if (sq_cnt_q >= 3'd1 && sq_cnt_q <= 3'd3) begin
						sum_a_q <= sum_a_q + prod_q;
					end else if (sq_cnt_q >= 3'd4) begin
						sum_g_q <= sum_g_q + prod_q;
					end
					sq_cnt_q <= sq_cnt_q + 3'd1;
					if (sq_cnt_q == 3'd6) begin
						rem_a_q <= sum_a_q;
						rem_g_q <= sum_g_q + prod_q;
						res_a_q <= '0;
						res_g_q <= '0;
						bit_q <= 32'h4000_0000;
						it_q <= '0;
						state_q <= imufd_pkg::ST_ROOT;
					end
				end
				imufd_pkg::ST_ROOT: begin
					if (rem_a_q >= try_a) begin
						rem_a_q <= rem_a_q - try_a;
						res_a_q <= (res_a_q >> 1) + bit_q;
					end else begin
						res_a_q <= res_a_q >> 1;
					end
					if (rem_g_q >= try_g) begin
						rem_g_q <= rem_g_q - try_g;
						res_g_q <= (res_g_q >> 1) + bit_q;
					end else begin
						res_g_q <= res_g_q >> 1;
					end
					bit_q <= bit_q >> 2;
					it_q <= it_q + 4'd1;
					if (it_q == 4'd15) begin
						state_q <= imufd_pkg::ST_WR;
					end
				end
				imufd_pkg::ST_WR: begin
					valid_q[wp_q] <= 1'b1;
					prev_a_q <= mag_a;
					prev_g_q <= mag_g;
					wp_q <= (wp_q == LAST_POS) ? '0 : wp_q + AW'(1);
					scan_q <= '0;
					acnt_q <= '0;
					gcnt_q <= '0;
					rd_en_s1 <= 1'b0;
					state_q <= imufd_pkg::ST_SCAN;
				end
				imufd_pkg::ST_SCAN: begin
					if (rd_en_s1 && rd_vld_s1) begin
						if (rd_data_s1[15:0] > accel_thr_q) begin
							acnt_q <= acnt_q + CW'(1);
						end
						if (rd_data_s1[31:16] > gyro_thr_q) begin
							gcnt_q <= gcnt_q + CW'(1);
						end
					end
					if (scan_q != SCAN_END) begin
						scan_q <= scan_q + CW'(1);
						rd_en_s1 <= 1'b1;
					end else begin
						rd_en_s1 <= 1'b0;
						if (!rd_en_s1) begin
							state_q <= imufd_pkg::ST_DEC;
						end
					end
				end
				imufd_pkg::ST_DEC: begin
					if (out_free) begin
						if (cand) begin
							valid_q <= '0;
						end
						held_q <= alarm ? 1'b0 : held_n;
						ticks_q <= alarm ? 16'd0 : ticks_n;
						m_tvalid <= 1'b1;
						m_tdata <= {6'd0, cand, alarm};
						state_q <= imufd_pkg::ST_IDLE;
					end
				end
				default: state_q <= imufd_pkg::ST_IDLE;
			endcase
		end
	end

	`FD_ASSERT_NEVER(a_alarm_with_cand, m_tvalid && m_tdata[0] && m_tdata[1], "alarm and candidate together")
	`FD_ASSERT(a_result_from_dec, $rose(m_tvalid) |-> $past(state_q == imufd_pkg::ST_DEC), "result outside decision")
	`FD_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state_q == imufd_pkg::ST_SQ), "accepted beat not started")
	`FD_ASSERT(a_scan_bound, (state_q == imufd_pkg::ST_SCAN) |-> (scan_q <= SCAN_END), "scan ran past window")
endmodule

// ===== bench/imu_fall_detector_tb.sv =====
`timescale 1ns / 100ps

module imu_fall_detector_tb;
	localparam int WLEN = imufd_pkg::WINDOW_LEN_DEF;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [imufd_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic signed [imufd_pkg::AXIS_W-1:0] gz;
		logic signed [imufd_pkg::AXIS_W-1:0] gy;
		logic signed [imufd_pkg::AXIS_W-1:0] gx;
		logic signed [imufd_pkg::AXIS_W-1:0] az;
		logic signed [imufd_pkg::AXIS_W-1:0] ay;
		logic signed [imufd_pkg::AXIS_W-1:0] ax;
	} imu_sample_t;

	typedef struct packed {
		logic candidate;
		logic alarm;
	} verdict_t;

	typedef struct {
		imu_sample_t smp;
		bit typed;
		verdict_t want;
	} sample_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [imufd_pkg::IDX_W-1:0] cfg_index;
	logic [imufd_pkg::CFG_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;

	imu_fall_detector dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	logic [imufd_pkg::THR_W-1:0] accel_thr, gyro_thr, quiet_lim;
	logic [imufd_pkg::LIM_W-1:0] accel_lim, gyro_lim;
	logic [15:0] last_accel_mag, last_gyro_mag;
	logic [15:0] accel_jerks[WLEN];
	logic [15:0] gyro_jerks[WLEN];
	int unsigned slot;
	bit held;
	int unsigned quiet_ticks;

	verdict_t pending_verdicts[$];
	sample_row_t directed_rows[$];
	int errors = 0;
	int samples_sent = 0;
	int verdicts_seen = 0;
	int candidates_seen = 0;
	int alarms_seen = 0;
	int idle_cycles = 0;
	bit steady_receiver = 0;
	bit steady_sender = 0;
	int shake_phase = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] floor_root(input logic [31:0] n);
		logic [31:0] root;
		logic [31:0] probe;
		root = 0;
		probe = 32'h4000_0000;
		while (probe > n)
			probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[15:0];
	endfunction

	function automatic logic [15:0] vector_length(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic signed [15:0] c);
		longint sa, sb, sc;
		sa = a;
		sb = b;
		sc = c;
		return floor_root(32'(sa * sa + sb * sb + sc * sc));
	endfunction

	function automatic logic [15:0] distance(input logic [15:0] x, input logic [15:0] y);
		return (x > y) ? x - y : y - x;
	endfunction

	task automatic restore_defaults();
		accel_thr = imufd_pkg::ACCEL_THR_RST;
		gyro_thr = imufd_pkg::GYRO_THR_RST;
		accel_lim = imufd_pkg::ACCEL_LIM_RST;
		gyro_lim = imufd_pkg::GYRO_LIM_RST;
		quiet_lim = imufd_pkg::QUIET_RST;
		last_accel_mag = 0;
		last_gyro_mag = 0;
		foreach (accel_jerks[i]) begin
			accel_jerks[i] = 0;
			gyro_jerks[i] = 0;
		end
		slot = 0;
		held = 0;
		quiet_ticks = 0;
	endtask

	function automatic verdict_t judge_sample(input imu_sample_t s);
		logic [15:0] amag, gmag;
		int unsigned acount, gcount;
		verdict_t v;
		amag = vector_length(s.ax, s.ay, s.az);
		gmag = vector_length(s.gx, s.gy, s.gz);
		accel_jerks[slot] = distance(amag, last_accel_mag);
		gyro_jerks[slot] = distance(gmag, last_gyro_mag);
		slot = (slot + 1 >= WLEN) ? 0 : slot + 1;
		last_accel_mag = amag;
		last_gyro_mag = gmag;
		acount = 0;
		gcount = 0;
		for (int i = 0; i < WLEN; i++) begin
			if (accel_jerks[i] > accel_thr)
				acount++;
			if (gyro_jerks[i] > gyro_thr)
				gcount++;
		end
		v.candidate = (acount > accel_lim) && (gcount > gyro_lim);
		v.alarm = 0;
		if (v.candidate) begin
			foreach (accel_jerks[i]) begin
				accel_jerks[i] = 0;
				gyro_jerks[i] = 0;
			end
			held = 1;
			quiet_ticks = 0;
		end else if (quiet_ticks < imufd_pkg::TICK_MAX) begin
			quiet_ticks++;
		end
		if (held && quiet_ticks > quiet_lim) begin
			v.alarm = 1;
			held = 0;
			quiet_ticks = 0;
		end
		return v;
	endfunction

	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The handshake is sampled at the edge, before the edge's own updates land.
	always @(posedge clk) begin
		verdict_t got, want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[1:0];
			verdicts_seen++;
			candidates_seen += got.candidate;
			alarms_seen += got.alarm;
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result beat %0d with nothing expected, data %h",
						verdicts_seen, m_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want || m_tdata[7:2] !== 6'd0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result beat %0d: alarm %b/%b candidate %b/%b fill %h",
							verdicts_seen, got.alarm, want.alarm, got.candidate,
							want.candidate, m_tdata[7:2]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending_verdicts.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int stall;
		m_tready = 0;
		@(posedge clk);
		forever begin
			stall = pick_gap(steady_receiver);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_sample(input imu_sample_t s, input bit typed, input verdict_t want);
		verdict_t v;
		int gap;
		s_tvalid <= 1;
		s_tdata <= s;
		do
			@(posedge clk);
		while (!s_tready);
		v = judge_sample(s);
		pending_verdicts.push_back(typed ? want : v);
		samples_sent++;
		gap = pick_gap(steady_sender);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (s_tvalid) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [imufd_pkg::IDX_W-1:0] idx,
			input logic [imufd_pkg::CFG_W-1:0] val);
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			imufd_pkg::REG_ACCEL_THR: accel_thr = val;
			imufd_pkg::REG_GYRO_THR: gyro_thr = val;
			imufd_pkg::REG_ACCEL_LIM: accel_lim = val[imufd_pkg::LIM_W-1:0];
			imufd_pkg::REG_GYRO_LIM: gyro_lim = val[imufd_pkg::LIM_W-1:0];
			imufd_pkg::REG_QUIET: quiet_lim = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [imufd_pkg::CFG_W-1:0] athr,
			input logic [imufd_pkg::CFG_W-1:0] gthr,
			input logic [imufd_pkg::CFG_W-1:0] alim, input logic [imufd_pkg::CFG_W-1:0] glim,
			input logic [imufd_pkg::CFG_W-1:0] quiet);
		wait_drained();
		write_reg(imufd_pkg::REG_ACCEL_THR, athr);
		write_reg(imufd_pkg::REG_GYRO_THR, gthr);
		write_reg(imufd_pkg::REG_ACCEL_LIM, alim);
		write_reg(imufd_pkg::REG_GYRO_LIM, glim);
		write_reg(imufd_pkg::REG_QUIET, quiet);
		write_reg(REG_UNMAPPED, 16'($urandom));
		cfg_wen <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] strong_axis();
		logic signed [15:0] v;
		v = 16'($urandom_range(6000, 32767));
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic logic signed [15:0] weak_axis();
		return 16'($signed($urandom_range(0, 400)) - 200);
	endfunction

	function automatic imu_sample_t make_sample();
		imu_sample_t s;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			shake_phase++;
			if (shake_phase[0])
				s = '{strong_axis(), weak_axis(), weak_axis(),
					weak_axis(), strong_axis(), weak_axis()};
			else
				s = '{weak_axis(), weak_axis(), weak_axis(),
					weak_axis(), weak_axis(), weak_axis()};
		end else if (kind < 85) begin
			s = '{weak_axis(), weak_axis(), weak_axis(),
				weak_axis(), weak_axis(), weak_axis()};
		end else if (kind < 95) begin
			s = {$urandom, $urandom, $urandom};
		end else begin
			s = $urandom_range(0, 1) ? {6{16'sh8000}} : {6{16'sh7FFF}};
		end
		return s;
	endfunction

	task automatic run_phase(input int count);
		steady_sender = ($urandom_range(0, 3) == 0);
		steady_receiver = ($urandom_range(0, 3) == 0);
		repeat (count) begin
			send_sample(make_sample(), 0, '0);
		end
		steady_sender = 0;
		steady_receiver = 0;
	endtask

	initial begin
		imu_sample_t zero_s, lo_s, hi_s, big_s;
		verdict_t quiet_v;
		arst_n = 0;
		cfg_wen = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		restore_defaults();
		quiet_v = '0;
		zero_s = '0;
		lo_s = {6{16'sh8000}};
		hi_s = {6{16'sh7FFF}};
		big_s = '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000};

		// A sample at rest, the extremes of every axis, then a violent shake that
		// crosses both window counts under the default settings.
		directed_rows.push_back('{zero_s, 1, quiet_v});
		directed_rows.push_back('{lo_s, 1, quiet_v});
		directed_rows.push_back('{hi_s, 0, quiet_v});
		directed_rows.push_back('{zero_s, 0, quiet_v});
		directed_rows.push_back('{{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000}, 0, quiet_v});
		directed_rows.push_back('{{16'sh0001, 16'shFFFF, 16'sh0000, 16'sh8000, 16'sh0000,
			16'sh0001}, 0, quiet_v});
		for (int i = 0; i < 16; i++)
			directed_rows.push_back('{(i % 2) ? zero_s : big_s, 0, quiet_v});
		directed_rows.push_back('{zero_s, 0, quiet_v});

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);

		run_phase(150);
		configure(16'd500, 16'd200, 16'd2, 16'd1, 16'd5);
		run_phase(80);
		wait_drained();
		run_phase(80);
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(150);
		configure(16'hFFFF, 16'hFFFF, 16'd64, 16'd64, 16'hFFFF);
		run_phase(120);
		configure(16'd1000, 16'd800, 16'hFF83, 16'd1, 16'hFFFF);
		run_phase(150);
		configure(16'd3000, 16'd3000, 16'd8, 16'd4, 16'd30);
		run_phase(150);
		for (int p = 0; p < 3; p++) begin
			configure(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
				16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
				16'($urandom_range(0, 40)));
			run_phase(110);
		end

		wait_drained();
		$display("Sent %0d IMU samples over several threshold, limit and quiet settings,",
			samples_sent);
		$display("checked %0d results with %0d fall candidates and %0d alarms.",
			verdicts_seen, candidates_seen, alarms_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
